// ===== src/c_subset_lexer_macros.svh =====
// Assertion helpers used by the checker of this block.
`ifndef C_SUBSET_LEXER_MACROS_SVH
`define C_SUBSET_LEXER_MACROS_SVH

// Check a property on every rising clock edge, reset windows included.
`define CSL_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

// Check a property on every rising clock edge outside reset.
`define CSL_ASSERT_RUN(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

`endif

// ===== src/csl_pkg.sv =====
package csl_pkg;

   localparam int MAX_VALUE_LEN_DEF = 63;
   localparam int LINE_BITS_DEF     = 20;
   localparam int COL_BITS          = 16;
   localparam int LEN_OUT_BITS      = 6;
   localparam int TYPE_BITS         = 6;
   localparam int SLOTS             = 3;
   localparam int QUEUE_DEPTH       = 8;

   typedef enum logic [3:0] {
      M_IDLE,
      M_IDENT,
      M_NUMBER,
      M_STRING,
      M_STR_ESC,
      M_CHR_OPEN,
      M_CHR_ESC,
      M_CHR_CLOSE,
      M_OP,
      M_LINE_CMT,
      M_BLOCK_CMT,
      M_BLOCK_STAR
   } mode_type;

   localparam logic [TYPE_BITS-1:0] TK_EOF      = 6'd0;
   localparam logic [TYPE_BITS-1:0] TK_IDENT    = 6'd1;
   localparam logic [TYPE_BITS-1:0] TK_NUMBER   = 6'd2;
   localparam logic [TYPE_BITS-1:0] TK_STRING   = 6'd3;
   localparam logic [TYPE_BITS-1:0] TK_CHAR     = 6'd4;
   localparam logic [TYPE_BITS-1:0] TK_INT      = 6'd5;
   localparam logic [TYPE_BITS-1:0] TK_RETURN   = 6'd6;
   localparam logic [TYPE_BITS-1:0] TK_IF       = 6'd7;
   localparam logic [TYPE_BITS-1:0] TK_ELSE     = 6'd8;
   localparam logic [TYPE_BITS-1:0] TK_WHILE    = 6'd9;
   localparam logic [TYPE_BITS-1:0] TK_FOR      = 6'd10;
   localparam logic [TYPE_BITS-1:0] TK_BREAK    = 6'd11;
   localparam logic [TYPE_BITS-1:0] TK_CONTINUE = 6'd12;
   localparam logic [TYPE_BITS-1:0] TK_SIZEOF   = 6'd13;
   localparam logic [TYPE_BITS-1:0] TK_EXTERN   = 6'd14;
   localparam logic [TYPE_BITS-1:0] TK_STATIC   = 6'd15;
   localparam logic [TYPE_BITS-1:0] TK_VOID     = 6'd16;
   localparam logic [TYPE_BITS-1:0] TK_CHAR_KW  = 6'd17;
   localparam logic [TYPE_BITS-1:0] TK_PLUS     = 6'd18;
   localparam logic [TYPE_BITS-1:0] TK_MINUS    = 6'd19;
   localparam logic [TYPE_BITS-1:0] TK_STAR     = 6'd20;
   localparam logic [TYPE_BITS-1:0] TK_SLASH    = 6'd21;
   localparam logic [TYPE_BITS-1:0] TK_PERCENT  = 6'd22;
   localparam logic [TYPE_BITS-1:0] TK_LT       = 6'd23;
   localparam logic [TYPE_BITS-1:0] TK_GT       = 6'd24;
   localparam logic [TYPE_BITS-1:0] TK_LE       = 6'd25;
   localparam logic [TYPE_BITS-1:0] TK_GE       = 6'd26;
   localparam logic [TYPE_BITS-1:0] TK_EQ       = 6'd27;
   localparam logic [TYPE_BITS-1:0] TK_NE       = 6'd28;
   localparam logic [TYPE_BITS-1:0] TK_AND      = 6'd29;
   localparam logic [TYPE_BITS-1:0] TK_OR       = 6'd30;
   localparam logic [TYPE_BITS-1:0] TK_NOT      = 6'd31;
   localparam logic [TYPE_BITS-1:0] TK_ASSIGN   = 6'd32;
   localparam logic [TYPE_BITS-1:0] TK_PLUS_EQ  = 6'd33;
   localparam logic [TYPE_BITS-1:0] TK_MINUS_EQ = 6'd34;
   localparam logic [TYPE_BITS-1:0] TK_INC      = 6'd35;
   localparam logic [TYPE_BITS-1:0] TK_DEC      = 6'd36;
   localparam logic [TYPE_BITS-1:0] TK_LBRACE   = 6'd37;
   localparam logic [TYPE_BITS-1:0] TK_RBRACE   = 6'd38;
   localparam logic [TYPE_BITS-1:0] TK_LPAREN   = 6'd39;
   localparam logic [TYPE_BITS-1:0] TK_RPAREN   = 6'd40;
   localparam logic [TYPE_BITS-1:0] TK_LBRACKET = 6'd41;
   localparam logic [TYPE_BITS-1:0] TK_RBRACKET = 6'd42;
   localparam logic [TYPE_BITS-1:0] TK_SEMI     = 6'd43;
   localparam logic [TYPE_BITS-1:0] TK_COMMA    = 6'd44;
   localparam logic [TYPE_BITS-1:0] TK_COLON    = 6'd45;
   localparam logic [TYPE_BITS-1:0] TK_DOT      = 6'd46;
   localparam logic [TYPE_BITS-1:0] TK_ARROW    = 6'd47;
   localparam logic [TYPE_BITS-1:0] TK_AMP      = 6'd48;

endpackage

// ===== src/csl_core.sv =====
module csl_core #(
   parameter int MAX_VALUE_LEN = csl_pkg::MAX_VALUE_LEN_DEF,
   parameter int LINE_BITS     = csl_pkg::LINE_BITS_DEF,
   localparam int REC_W        = LINE_BITS + 38
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   in_fire,
   input  logic [7:0]                             in_byte,
   input  logic                                   in_end,
   output logic [1:0]                             res_count,
   output logic [csl_pkg::SLOTS-1:0][REC_W-1:0]   res_data
);
   import csl_pkg::*;

   localparam int LEN_BITS = $clog2(MAX_VALUE_LEN + 1);

   typedef struct packed {
      logic                    last;
      logic [LEN_OUT_BITS-1:0] len;
      logic [COL_BITS-1:0]     col;
      logic [LINE_BITS-1:0]    line;
      logic [TYPE_BITS-1:0]    ttype;
      logic [7:0]              vb;
      logic                    kind;
   } rec_type;

   typedef struct packed {
      logic                 push;
      logic [7:0]           push_byte;
      logic                 fin;
      logic [TYPE_BITS-1:0] fin_type;
      logic                 start;
      logic                 fpush;
      logic                 ffin;
      logic [TYPE_BITS-1:0] ftype;
      logic                 eof;
   } ctl_type;

   mode_type             mode_ff, mode_in;
   logic [7:0]           pend_ff, pend_in;
   logic [63:0]          kw_ff, kw_in;
   logic [LEN_BITS-1:0]  tlen_ff, tlen_in;
   logic [LINE_BITS-1:0] line_ff, line_in, tline_ff, tline_in;
   logic [COL_BITS-1:0]  col_ff, col_in, tcol_ff, tcol_in;
   ctl_type              ctl;
   logic [TYPE_BITS-1:0] ident_code;
   rec_type              res [SLOTS];
   logic [1:0]           cnt;

   function automatic logic is_alpha(input logic [7:0] b);
      return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_";
   endfunction

   function automatic logic is_digit(input logic [7:0] b);
      return b >= "0" && b <= "9";
   endfunction

   function automatic logic [7:0] unescape(input logic [7:0] b);
      logic [7:0] r;
      r = b;
      if (b == "n") r = 8'h0a;
      else if (b == "t") r = 8'h09;
      else if (b == "r") r = 8'h0d;
      return r;
   endfunction

   function automatic logic [TYPE_BITS-1:0] op_single(input logic [7:0] p);
      logic [TYPE_BITS-1:0] r;
      case (p)
         "+":     r = TK_PLUS;
         "-":     r = TK_MINUS;
         "<":     r = TK_LT;
         ">":     r = TK_GT;
         "=":     r = TK_ASSIGN;
         "!":     r = TK_NOT;
         "&":     r = TK_AMP;
         "|":     r = TK_OR;
         "/":     r = TK_SLASH;
         default: r = TK_EOF;
      endcase
      return r;
   endfunction

   function automatic logic [TYPE_BITS-1:0] op_pair(input logic [7:0] p, input logic [7:0] b);
      logic [TYPE_BITS-1:0] r;
      r = TK_EOF;
      if (p == "+" && b == "+") r = TK_INC;
      else if (p == "+" && b == "=") r = TK_PLUS_EQ;
      else if (p == "-" && b == "-") r = TK_DEC;
      else if (p == "-" && b == "=") r = TK_MINUS_EQ;
      else if (p == "-" && b == ">") r = TK_ARROW;
      else if (p == "<" && b == "=") r = TK_LE;
      else if (p == ">" && b == "=") r = TK_GE;
      else if (p == "=" && b == "=") r = TK_EQ;
      else if (p == "!" && b == "=") r = TK_NE;
      else if (p == "&" && b == "&") r = TK_AND;
      else if (p == "|" && b == "|") r = TK_OR;
      return r;
   endfunction

   function automatic logic [TYPE_BITS-1:0] punct(input logic [7:0] b);
      logic [TYPE_BITS-1:0] r;
      case (b)
         "*":     r = TK_STAR;
         "%":     r = TK_PERCENT;
         "{":     r = TK_LBRACE;
         "}":     r = TK_RBRACE;
         "(":     r = TK_LPAREN;
         ")":     r = TK_RPAREN;
         "[":     r = TK_LBRACKET;
         "]":     r = TK_RBRACKET;
         ";":     r = TK_SEMI;
         ",":     r = TK_COMMA;
         ":":     r = TK_COLON;
         ".":     r = TK_DOT;
         default: r = TK_EOF;
      endcase
      return r;
   endfunction

   // Keywords packed first byte lowest, zero filled.
   function automatic logic [TYPE_BITS-1:0] kw_lookup(input logic [63:0] kw,
                                                      input logic [3:0] n);
      logic [TYPE_BITS-1:0] r;
      r = TK_IDENT;
      if (n == 4'd3 && kw == 64'h746e69) r = TK_INT;
      else if (n == 4'd4 && kw == 64'h64696f76) r = TK_VOID;
      else if (n == 4'd4 && kw == 64'h72616863) r = TK_CHAR_KW;
      else if (n == 4'd6 && kw == 64'h6e7275746572) r = TK_RETURN;
      else if (n == 4'd2 && kw == 64'h6669) r = TK_IF;
      else if (n == 4'd4 && kw == 64'h65736c65) r = TK_ELSE;
      else if (n == 4'd5 && kw == 64'h656c696877) r = TK_WHILE;
      else if (n == 4'd3 && kw == 64'h726f66) r = TK_FOR;
      else if (n == 4'd5 && kw == 64'h6b61657262) r = TK_BREAK;
      else if (n == 4'd8 && kw == 64'h65756e69746e6f63) r = TK_CONTINUE;
      else if (n == 4'd6 && kw == 64'h666f657a6973) r = TK_SIZEOF;
      else if (n == 4'd6 && kw == 64'h6e7265747865) r = TK_EXTERN;
      else if (n == 4'd6 && kw == 64'h636974617473) r = TK_STATIC;
      return r;
   endfunction

   function automatic logic [LEN_OUT_BITS-1:0] len_out(input logic [LEN_BITS-1:0] n);
      logic [LEN_BITS+LEN_OUT_BITS-1:0] w;
      w = {{LEN_OUT_BITS{1'b0}}, n};
      return w[LEN_OUT_BITS-1:0];
   endfunction

   assign ident_code = (tlen_ff > LEN_BITS'(8)) ? TK_IDENT : kw_lookup(kw_ff, tlen_ff[3:0]);

   // Next state and per-byte decisions.
   always_comb begin
      logic fresh;
      ctl     = '0;
      mode_in = mode_ff;
      pend_in = pend_ff;
      fresh   = 1'b0;
      if (in_end) begin
         ctl.eof = 1'b1;
         mode_in = M_IDLE;
         pend_in = '0;
         case (mode_ff)
            M_IDENT:     begin ctl.fin = 1'b1; ctl.fin_type = ident_code; end
            M_NUMBER:    begin ctl.fin = 1'b1; ctl.fin_type = TK_NUMBER; end
            M_STRING:    begin ctl.fin = 1'b1; ctl.fin_type = TK_STRING; end
            M_STR_ESC: begin
               ctl.push = 1'b1; ctl.push_byte = "\\";
               ctl.fin = 1'b1; ctl.fin_type = TK_STRING;
            end
            M_CHR_OPEN:  begin ctl.fin = 1'b1; ctl.fin_type = TK_CHAR; end
            M_CHR_ESC: begin
               ctl.push = 1'b1; ctl.push_byte = "\\";
               ctl.fin = 1'b1; ctl.fin_type = TK_CHAR;
            end
            M_CHR_CLOSE: begin ctl.fin = 1'b1; ctl.fin_type = TK_CHAR; end
            M_OP:        begin ctl.fin = 1'b1; ctl.fin_type = op_single(pend_ff); end
            default: ;
         endcase
      end else begin
         case (mode_ff)
            M_IDENT: begin
               if (is_alpha(in_byte) || is_digit(in_byte)) begin
                  ctl.push = 1'b1; ctl.push_byte = in_byte;
               end else begin
                  ctl.fin = 1'b1; ctl.fin_type = ident_code; fresh = 1'b1;
               end
            end
            M_NUMBER: begin
               if (is_digit(in_byte)) begin
                  ctl.push = 1'b1; ctl.push_byte = in_byte;
               end else begin
                  ctl.fin = 1'b1; ctl.fin_type = TK_NUMBER; fresh = 1'b1;
               end
            end
            M_STRING: begin
               if (in_byte == "\"") begin
                  ctl.fin = 1'b1; ctl.fin_type = TK_STRING; mode_in = M_IDLE;
               end else if (in_byte == "\\") begin
                  mode_in = M_STR_ESC;
               end else begin
                  ctl.push = 1'b1; ctl.push_byte = in_byte;
               end
            end
            M_STR_ESC: begin
               ctl.push = 1'b1; ctl.push_byte = unescape(in_byte); mode_in = M_STRING;
            end
            M_CHR_OPEN: begin
               if (in_byte == "\\") begin
                  mode_in = M_CHR_ESC;
               end else begin
                  ctl.push = 1'b1; ctl.push_byte = in_byte; mode_in = M_CHR_CLOSE;
               end
            end
            M_CHR_ESC: begin
               ctl.push = 1'b1; ctl.push_byte = unescape(in_byte); mode_in = M_CHR_CLOSE;
            end
            M_CHR_CLOSE: begin
               ctl.fin = 1'b1; ctl.fin_type = TK_CHAR; mode_in = M_IDLE;
               fresh = (in_byte != "'");
            end
            M_OP: begin
               if (pend_ff == "/" && in_byte == "/") begin
                  mode_in = M_LINE_CMT;
               end else if (pend_ff == "/" && in_byte == "*") begin
                  mode_in = M_BLOCK_CMT;
               end else if (op_pair(pend_ff, in_byte) != TK_EOF) begin
                  ctl.fin = 1'b1; ctl.fin_type = op_pair(pend_ff, in_byte); mode_in = M_IDLE;
               end else begin
                  ctl.fin = 1'b1; ctl.fin_type = op_single(pend_ff); fresh = 1'b1;
               end
            end
            M_LINE_CMT: begin
               if (in_byte == 8'h0a) mode_in = M_IDLE;
            end
            M_BLOCK_CMT: begin
               if (in_byte == "*") mode_in = M_BLOCK_STAR;
            end
            M_BLOCK_STAR: begin
               if (in_byte == "/") mode_in = M_IDLE;
               else if (in_byte != "*") mode_in = M_BLOCK_CMT;
            end
            default: fresh = 1'b1;
         endcase
      end
      // Lex the byte as the start of something new.
      if (fresh) begin
         mode_in = M_IDLE;
         if (in_byte == " " || in_byte == 8'h09 || in_byte == 8'h0a || in_byte == 8'h0d) begin
         end else if (is_alpha(in_byte)) begin
            ctl.start = 1'b1; ctl.fpush = 1'b1; mode_in = M_IDENT;
         end else if (is_digit(in_byte)) begin
            ctl.start = 1'b1; ctl.fpush = 1'b1; mode_in = M_NUMBER;
         end else if (in_byte == "\"") begin
            ctl.start = 1'b1; mode_in = M_STRING;
         end else if (in_byte == "'") begin
            ctl.start = 1'b1; mode_in = M_CHR_OPEN;
         end else if (op_single(in_byte) != TK_EOF) begin
            ctl.start = 1'b1; mode_in = M_OP; pend_in = in_byte;
         end else begin
            ctl.start = 1'b1; ctl.ffin = 1'b1; ctl.ftype = punct(in_byte);
         end
      end
   end

   // Token datapath and result words.
   always_comb begin
      logic [LEN_BITS-1:0] len_a;
      kw_in    = kw_ff;
      tlen_in  = tlen_ff;
      tline_in = tline_ff;
      tcol_in  = tcol_ff;
      line_in  = line_ff;
      col_in   = col_ff;
      cnt      = 2'd0;
      for (int i = 0; i < SLOTS; i++) res[i] = '0;
      len_a = tlen_ff;
      if (ctl.push && tlen_ff < LEN_BITS'(MAX_VALUE_LEN)) begin
         if (tlen_ff < LEN_BITS'(8)) kw_in[{tlen_ff[2:0], 3'b000} +: 8] = ctl.push_byte;
         len_a   = tlen_ff + LEN_BITS'(1);
         tlen_in = len_a;
         res[cnt] = '{last: 1'b0, len: len_out(len_a), col: tcol_ff, line: tline_ff,
                      ttype: TK_EOF, vb: ctl.push_byte, kind: 1'b0};
         cnt = cnt + 2'd1;
      end
      if (ctl.fin) begin
         res[cnt] = '{last: 1'b0, len: len_out(len_a), col: tcol_ff, line: tline_ff,
                      ttype: ctl.fin_type, vb: 8'd0, kind: 1'b1};
         cnt = cnt + 2'd1;
      end
      if (ctl.start) begin
         tline_in = line_ff;
         tcol_in  = col_ff;
         tlen_in  = '0;
         kw_in    = '0;
      end
      if (ctl.fpush) begin
         kw_in   = {56'd0, in_byte};
         tlen_in = LEN_BITS'(1);
         res[cnt] = '{last: 1'b0, len: LEN_OUT_BITS'(1), col: col_ff, line: line_ff,
                      ttype: TK_EOF, vb: in_byte, kind: 1'b0};
         cnt = cnt + 2'd1;
      end
      if (ctl.ffin) begin
         res[cnt] = '{last: 1'b0, len: '0, col: col_ff, line: line_ff,
                      ttype: ctl.ftype, vb: 8'd0, kind: 1'b1};
         cnt = cnt + 2'd1;
      end
      if (ctl.eof) begin
         res[cnt] = '{last: 1'b0, len: '0, col: col_ff, line: line_ff,
                      ttype: TK_EOF, vb: 8'd0, kind: 1'b1};
         cnt = cnt + 2'd1;
         kw_in    = '0;
         tlen_in  = '0;
         line_in  = LINE_BITS'(1);
         col_in   = COL_BITS'(1);
         tline_in = LINE_BITS'(1);
         tcol_in  = COL_BITS'(1);
      end else if (in_byte == 8'h0a) begin
         if (line_ff != '1) line_in = line_ff + LINE_BITS'(1);
         col_in = COL_BITS'(1);
      end else if (col_ff != '1) begin
         col_in = col_ff + COL_BITS'(1);
      end
      if (cnt != 2'd0) res[cnt - 2'd1].last = 1'b1;
   end

   always_comb begin
      res_count = in_fire ? cnt : 2'd0;
      for (int i = 0; i < SLOTS; i++) res_data[i] = res[i];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= M_IDLE;
         pend_ff  <= '0;
         kw_ff    <= '0;
         tlen_ff  <= '0;
         line_ff  <= LINE_BITS'(1);
         col_ff   <= COL_BITS'(1);
         tline_ff <= LINE_BITS'(1);
         tcol_ff  <= COL_BITS'(1);
      end else if (in_fire) begin
         mode_ff  <= mode_in;
         pend_ff  <= pend_in;
         kw_ff    <= kw_in;
         tlen_ff  <= tlen_in;
         line_ff  <= line_in;
         col_ff   <= col_in;
         tline_ff <= tline_in;
         tcol_ff  <= tcol_in;
      end
   end

endmodule

// ===== src/csl_queue.sv =====
module csl_queue #(
   parameter int WIDTH = 58,
   parameter int DEPTH = csl_pkg::QUEUE_DEPTH
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic [1:0]                             push_count,
   input  logic [csl_pkg::SLOTS-1:0][WIDTH-1:0]   push_data,
   output logic                                   space_ok,
   output logic                                   out_valid,
   input  logic                                   out_ready,
   output logic [WIDTH-1:0]                       out_data
);
   import csl_pkg::*;

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [PW-1:0]    wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             pop;

   assign out_valid = (count_ff != '0);
   assign out_data  = mem[rd_ff];
   assign pop       = out_valid && out_ready;
   // Room for the largest burst one byte can cause.
   assign space_ok  = (count_ff <= CW'(DEPTH - SLOTS));

   always_comb begin
      wr_in    = wr_ff + PW'(push_count);
      rd_in    = pop ? rd_ff + PW'(1) : rd_ff;
      count_in = count_ff + CW'(push_count) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < SLOTS; i++) begin
         if (2'(i) < push_count) mem[wr_ff + PW'(i)] <= push_data[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

endmodule

// ===== src/c_subset_lexer.sv =====
// C subset lexer. One source byte is taken per clock on the req side (end of
// source is a word with req_tlast high; its byte is ignored, pending tokens are
// flushed, an EOF record follows and the lexer returns to its reset state).
// Each byte is lexed in the cycle it is accepted and gives zero to three result
// words: streamed value bytes (tuser 0) and token records (tuser 1) with type,
// start line, start column and kept length; rsp_tlast marks the last word of a
// byte. Results drain one per clock with rsp_tready high through an eight-entry
// result queue; req_tready is high while it has room for three words, so the
// sustained rate is one byte per cycle if results average at most one per byte.
module c_subset_lexer #(
   parameter int MAX_VALUE_LEN = csl_pkg::MAX_VALUE_LEN_DEF,
   parameter int LINE_BITS     = csl_pkg::LINE_BITS_DEF,
   localparam int TDATA_BITS   = (LINE_BITS + 36 + 7) / 8 * 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,   // src_byte
   input  logic                  req_tlast,   // end_of_input
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // value_byte, token_type, start_line, start_column, value_length
   output logic [TDATA_BITS-1:0] rsp_tdata,
   output logic                  rsp_tuser,   // record_kind
   output logic                  rsp_tlast    // last_of_run
);
   import csl_pkg::*;

   localparam int REC_W = LINE_BITS + 38;

   logic                             fire;
   logic [1:0]                       res_count;
   logic [SLOTS-1:0][REC_W-1:0]      res_data;
   logic [REC_W-1:0]                 head;

   assign fire = req_tvalid && req_tready;

   csl_core #(
      .MAX_VALUE_LEN (MAX_VALUE_LEN),
      .LINE_BITS     (LINE_BITS)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .in_fire   (fire),
      .in_byte   (req_tdata),
      .in_end    (req_tlast),
      .res_count (res_count),
      .res_data  (res_data)
   );

   csl_queue #(
      .WIDTH (REC_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_count (res_count),
      .push_data  (res_data),
      .space_ok   (req_tready),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_data   (head)
   );

   assign rsp_tuser = head[0];
   assign rsp_tdata = TDATA_BITS'(head[REC_W-2:1]);
   assign rsp_tlast = head[REC_W-1];

endmodule

// ===== src/csl_checker.sv =====
`include "c_subset_lexer_macros.svh"

module csl_checker #(
   parameter int DATA_W = 56
) (
   input logic              clock,
   input logic              reset,
   input logic              rsp_tvalid,
   input logic              rsp_tready,
   input logic [DATA_W-1:0] rsp_tdata,
   input logic              rsp_tuser
);

   `CSL_ASSERT(a_empty_after_reset, reset |=> !rsp_tvalid, "result valid right after reset")

   `CSL_ASSERT_RUN(a_hold_stalled, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata), "stalled result word changed")

   `CSL_ASSERT_RUN(a_value_no_type, rsp_tvalid && !rsp_tuser |-> rsp_tdata[13:8] == 6'd0, "value byte word carries a token type")

   `CSL_ASSERT_RUN(a_record_no_byte, rsp_tvalid && rsp_tuser |-> rsp_tdata[7:0] == 8'd0, "token record carries a value byte")

endmodule

bind c_subset_lexer csl_checker #(.DATA_W($bits(rsp_tdata))) u_csl_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
